@@ src/lsdrs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdrs_pkg: shared types and constants of the LSD decimal radix sorter
// Holds the sizing constants, the channel structs, the layout of one memory
// entry, the bucket control bundle and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 16;
	localparam int SAMPLE_W    = 16;
	localparam int RADIX       = 10;

	localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int DIGIT_W = $clog2(RADIX);
	localparam int ENTRY_W = 2 * VALUE_WIDTH;

	// x / 10 == (x * RECIP) >> RECIP_SHIFT for every x below 2**VALUE_WIDTH
	localparam int RECIP_SHIFT = VALUE_WIDTH + 3;
	localparam logic [VALUE_WIDTH-1:0] RECIP =
		VALUE_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic                final_item;
	} sort_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sorted_value;
		logic                run_end;
		logic                items_dropped;
	} sort_out_t;

	// One memory word: the original value and its quotient by the current weight
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [VALUE_WIDTH-1:0] quot;
	} entry_t;

	typedef struct packed {
		logic               clear;
		logic               count_en;
		logic               prefix_en;
		logic [DIGIT_W-1:0] prefix_idx;
		logic               take_en;
		logic [DIGIT_W-1:0] digit;
	} bkt_ctrl_t;

	function automatic logic [VALUE_WIDTH-1:0] div10(input logic [VALUE_WIDTH-1:0] x);
		logic [2*VALUE_WIDTH-1:0] prod;
		prod = (2*VALUE_WIDTH)'(x) * (2*VALUE_WIDTH)'(RECIP);
		return VALUE_WIDTH'(prod >> RECIP_SHIFT);
	endfunction

endpackage
`default_nettype wire

@@ src/lsd_decimal_radix_sort.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort: collect a set of values, sort it, stream it out
// Values enter one request per cycle and are written to a RAM while the
// running maximum is kept; requests beyond CAPACITY are dropped and flagged.
// A request marked final_item closes the set. The block then runs one LSD
// decimal pass per digit of the maximum (none if the maximum is zero). Each
// pass is a counting sweep over the RAM, a prefix sum over the ten bucket
// counters and a distribution sweep into the second RAM, which then becomes
// the source. Every RAM word carries the value and its quotient by the
// current power of ten, so a pass only divides by ten. Results then leave
// in ascending order, each read from the RAM and held until the downstream
// side accepts it; run_end marks the last one and items_dropped is set on
// every result of a set that lost requests. The sweeps over the single
// read port of each RAM set the sort time; 16-bit values need up to five
// passes. No new value is taken from the start of the sort until the last
// result has been accepted.
// ----------------------------------------------------------------------------
module lsd_decimal_radix_sort import lsdrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  sort_in_t  sample,
	output logic      result_valid,
	input  logic      result_stall,
	output sort_out_t result
);

	typedef enum logic [6:0] {
		ST_LOAD      = 7'b0000001,
		ST_COUNT     = 7'b0000010,
		ST_PREFIX    = 7'b0000100,
		ST_DIST      = 7'b0001000,
		ST_EMIT_RD   = 7'b0010000,
		ST_EMIT_WAIT = 7'b0100000,
		ST_EMIT_HOLD = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [VALUE_WIDTH-1:0] max_q;
	logic                   drop_q;
	logic                   sel_q;      // 0: ram0 holds the current order
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   rd_v_s1;
	logic [DIGIT_W-1:0]     prefix_idx_q;
	logic                   out_valid_q;
	sort_out_t              out_q;

	logic                   accept;
	logic                   room;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [VALUE_WIDTH-1:0] max_nxt;
	logic [VALUE_WIDTH-1:0] max_div;
	logic                   sweeping;
	logic                   issue;
	logic                   sweep_done;
	logic                   last_pos;

	logic [ENTRY_W-1:0]     ram0_rd;
	logic [ENTRY_W-1:0]     ram1_rd;
	logic                   ram0_we;
	logic                   ram1_we;
	logic [ADDR_W-1:0]      ram0_wa;
	logic [ENTRY_W-1:0]     ram0_wd;
	logic [ADDR_W-1:0]      rd_addr;
	entry_t                 src_entry;
	entry_t                 dist_entry;

	logic                   dig_valid;
	logic [VALUE_WIDTH-1:0] dig_value;
	logic [VALUE_WIDTH-1:0] dig_quot;
	logic [DIGIT_W-1:0]     dig_digit;
	bkt_ctrl_t              bkt_ctrl;
	logic [CNT_W-1:0]       bkt_offset;
	logic                   go_count;

	// ---- load side --------------------------------------------------------
	assign sample_stall = (state_q != ST_LOAD);
	assign accept       = sample_valid && !sample_stall;
	assign room         = (count_q < CNT_W'(CAPACITY));
	assign in_value     = VALUE_WIDTH'(sample.sample_value);
	assign max_nxt      = (room && (in_value > max_q)) ? in_value : max_q;
	assign max_div      = div10(max_q);

	// ---- sweep control shared by counting and distribution ----------------
	assign sweeping   = (state_q == ST_COUNT) || (state_q == ST_DIST);
	assign issue      = sweeping && (rd_idx_q < count_q);
	assign sweep_done = sweeping && (rd_idx_q == count_q) && !rd_v_s1 && !dig_valid;
	assign rd_addr    = rd_idx_q[ADDR_W-1:0];
	assign src_entry  = sel_q ? entry_t'(ram1_rd) : entry_t'(ram0_rd);
	assign last_pos   = ((rd_idx_q + 1'b1) == count_q);

	// Clear the buckets on every entry into a counting sweep
	assign go_count = (accept && sample.final_item && (max_nxt != '0))
		|| (state_q == ST_DIST && sweep_done && (max_div != '0));

	always_comb begin
		bkt_ctrl            = '0;
		bkt_ctrl.clear      = go_count;
		bkt_ctrl.count_en   = (state_q == ST_COUNT) && dig_valid;
		bkt_ctrl.prefix_en  = (state_q == ST_PREFIX);
		bkt_ctrl.prefix_idx = prefix_idx_q;
		bkt_ctrl.take_en    = (state_q == ST_DIST) && dig_valid;
		bkt_ctrl.digit      = dig_digit;
	end

	// ---- RAM write ports: load into ram0, distribute into the other one ---
	assign dist_entry.value = dig_value;
	assign dist_entry.quot  = dig_quot;

	always_comb begin
		ram0_we = 1'b0;
		ram0_wa = count_q[ADDR_W-1:0];
		ram0_wd = {in_value, in_value};
		if (state_q == ST_LOAD) begin
			ram0_we = accept && room;
		end else begin
			ram0_we = bkt_ctrl.take_en && sel_q;
			ram0_wa = bkt_offset[ADDR_W-1:0];
			ram0_wd = ENTRY_W'(dist_entry);
		end
	end

	assign ram1_we = bkt_ctrl.take_en && !sel_q;

	lsdrs_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_ram0 (
		.clk     (clk),
		.wr_en   (ram0_we),
		.wr_addr (ram0_wa),
		.wr_data (ram0_wd),
		.rd_addr (rd_addr),
		.rd_data (ram0_rd)
	);

	lsdrs_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_ram1 (
		.clk     (clk),
		.wr_en   (ram1_we),
		.wr_addr (bkt_offset[ADDR_W-1:0]),
		.wr_data (ENTRY_W'(dist_entry)),
		.rd_addr (rd_addr),
		.rd_data (ram1_rd)
	);

	lsdrs_digit u_digit (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (rd_v_s1 && sweeping),
		.entry       (src_entry),
		.digit_valid (dig_valid),
		.value       (dig_value),
		.quot        (dig_quot),
		.digit       (dig_digit)
	);

	lsdrs_buckets u_buckets (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bkt_ctrl),
		.offset (bkt_offset)
	);

	// ---- sequencer ---------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			max_q        <= '0;
			drop_q       <= 1'b0;
			sel_q        <= 1'b0;
			rd_idx_q     <= '0;
			rd_v_s1      <= 1'b0;
			prefix_idx_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						max_q <= max_nxt;
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (sample.final_item) begin
							rd_idx_q <= '0;
							// an all-zero set is already in order
							state_q  <= (max_nxt != '0) ? ST_COUNT : ST_EMIT_RD;
						end
					end
				end
				ST_COUNT: begin
					if (sweep_done) begin
						prefix_idx_q <= '0;
						state_q      <= ST_PREFIX;
					end
				end
				ST_PREFIX: begin
					prefix_idx_q <= prefix_idx_q + 1'b1;
					if (prefix_idx_q == DIGIT_W'(RADIX - 1)) begin
						rd_idx_q <= '0;
						state_q  <= ST_DIST;
					end
				end
				ST_DIST: begin
					if (sweep_done) begin
						// swap source and destination, advance the weight
						sel_q    <= !sel_q;
						max_q    <= max_div;
						rd_idx_q <= '0;
						state_q  <= (max_div != '0) ? ST_COUNT : ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					out_valid_q <= 1'b1;
					rd_idx_q    <= rd_idx_q + 1'b1;
					state_q     <= ST_EMIT_HOLD;
				end
				ST_EMIT_HOLD: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						if (out_q.run_end) begin
							count_q  <= '0;
							max_q    <= '0;
							drop_q   <= 1'b0;
							sel_q    <= 1'b0;
							rd_idx_q <= '0;
							state_q  <= ST_LOAD;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: loaded from the RAM data once per result
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_WAIT) begin
			out_q.sorted_value  <= SAMPLE_W'(src_entry.value);
			out_q.run_end       <= last_pos;
			out_q.items_dropped <= drop_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---- assertions --------------------------------------------------------
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= count_q)
		else $error("read index ran past the set");

	a_take_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bkt_ctrl.take_en |-> (bkt_offset < count_q))
		else $error("bucket offset outside the set");

	a_result_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q == ST_EMIT_HOLD) && sample_stall)
		else $error("result shown outside emission");

	a_one_result_per_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT_WAIT))
		else $error("result raised without a RAM read");

endmodule
`default_nettype wire

@@ src/lsdrs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdrs_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsdrs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ src/lsdrs_digit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdrs_digit: digit extraction stage
// Register the entry and its quotient by ten, then form the decimal digit
// as the remainder q - 10 * (q / 10).
// ----------------------------------------------------------------------------
module lsdrs_digit import lsdrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   entry_valid,
	input  entry_t                 entry,
	output logic                   digit_valid,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [VALUE_WIDTH-1:0] quot,
	output logic [DIGIT_W-1:0]     digit
);

	logic                   valid_s2;
	logic [VALUE_WIDTH-1:0] value_s2;
	logic [VALUE_WIDTH-1:0] q_s2;
	logic [VALUE_WIDTH-1:0] quot_s2;
	logic [VALUE_WIDTH-1:0] rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		value_s2 <= entry.value;
		q_s2     <= entry.quot;
		quot_s2  <= div10(entry.quot);
	end

	assign rem         = q_s2 - ((quot_s2 << 3) + (quot_s2 << 1));
	assign digit_valid = valid_s2;
	assign value       = value_s2;
	assign quot        = quot_s2;
	assign digit       = rem[DIGIT_W-1:0];

endmodule
`default_nettype wire

@@ src/lsdrs_buckets.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdrs_buckets: ten bucket counters / offsets
// Count digits, turn counts into start offsets one bucket a cycle, then
// hand out and advance the offset of a digit's bucket.
// ----------------------------------------------------------------------------
module lsdrs_buckets import lsdrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bkt_ctrl_t        ctrl,
	output logic [CNT_W-1:0] offset
);

	logic [CNT_W-1:0] bkt_q [RADIX];
	logic [CNT_W-1:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RADIX; i++) begin
				bkt_q[i] <= '0;
			end
			run_q <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < RADIX; i++) begin
				bkt_q[i] <= '0;
			end
			run_q <= '0;
		end else if (ctrl.count_en || ctrl.take_en) begin
			bkt_q[ctrl.digit] <= bkt_q[ctrl.digit] + 1'b1;
		end else if (ctrl.prefix_en) begin
			bkt_q[ctrl.prefix_idx] <= run_q;
			run_q                  <= run_q + bkt_q[ctrl.prefix_idx];
		end
	end

	assign offset = bkt_q[ctrl.digit];

endmodule
`default_nettype wire
